// ===== sv/vch_pkg.sv =====
// shared constants, types and helpers for the voxel coordinate hash table
// no dependencies; every other file refers to this package by scoped names
package vch_pkg;

  localparam int unsigned SLOT_AW     = 12;
  localparam int unsigned TABLE_DEPTH = 1 << SLOT_AW;
  localparam int unsigned COORD_BITS  = 21;
  localparam int unsigned KEY_W       = 3 * COORD_BITS;
  localparam int unsigned VALUE_W     = 20;
  localparam int unsigned LOG2_W      = 4;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned IN_TDATA_W  = ((KEY_W + VALUE_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((VALUE_W + 7) / 8) * 8;

  localparam logic [LOG2_W-1:0] TABLE_LOG2_RST = LOG2_W'(SLOT_AW);

  // finalizer multipliers
  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned MIX_SHIFT = 33;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic               used;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } slot_entry_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_AW-1:0] waddr;
    slot_entry_t        wdata;
    logic [SLOT_AW-1:0] raddr;
  } slot_port_t;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
  } hash_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] hash;
  } hash_rsp_t;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] value;
    logic               status;
  } result_t;

  // slot mask for a table of 2^log2 slots, capped at the memory depth
  function automatic logic [SLOT_AW-1:0] slot_mask(logic [LOG2_W-1:0] log2);
    logic [LOG2_W-1:0]  l;
    logic [SLOT_AW:0]   m;
    l = (log2 > LOG2_W'(SLOT_AW)) ? LOG2_W'(SLOT_AW) : log2;
    m = ((SLOT_AW + 1)'(1) << l) - (SLOT_AW + 1)'(1);
    return m[SLOT_AW-1:0];
  endfunction

endpackage

// ===== sv/vch_hash.sv =====
// 64-bit key finalizer: xor-shift, multiply, xor-shift, multiply, xor-shift
// one shared 32x32 multiplier, three partial products per multiply; uses vch_pkg
module vch_hash (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vch_pkg::hash_req_t req_i,
  output vch_pkg::hash_rsp_t rsp_o
);

  logic        busy_q, pass_q, done_q;
  logic [1:0]  step_q;
  logic [63:0] v_q, acc_q, prod_q;

  logic [63:0] key64, cst, mul_p, sum;
  logic [31:0] mul_a, mul_b;

  assign key64 = 64'(req_i.key);
  assign cst   = pass_q ? vch_pkg::MIX_C2 : vch_pkg::MIX_C1;
  assign mul_a = (step_q == 2'd2) ? v_q[63:32] : v_q[31:0];
  assign mul_b = (step_q == 2'd1) ? cst[63:32] : cst[31:0];
  assign mul_p = 64'(mul_a) * 64'(mul_b);
  // cross terms only reach the upper word
  assign sum   = acc_q + {prod_q[31:0], 32'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pass_q <= 1'b0;
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        pass_q <= 1'b0;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          if (pass_q) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
          pass_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      v_q <= key64 ^ (key64 >> vch_pkg::MIX_SHIFT);
    end else if (busy_q) begin
      case (step_q)
        2'd0: begin
          prod_q <= mul_p;
        end
        2'd1: begin
          acc_q  <= prod_q;
          prod_q <= mul_p;
        end
        2'd2: begin
          acc_q  <= sum;
          prod_q <= mul_p;
        end
        default: begin
          v_q <= sum ^ (sum >> vch_pkg::MIX_SHIFT);
        end
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.hash = v_q;

endmodule

// ===== sv/vch_slot_ram.sv =====
// slot memory: used flag, key and value per slot, one write and one read port
// read data registered; uses vch_pkg
module vch_slot_ram (
  input  logic                 clk_i,
  input  vch_pkg::slot_port_t  port_i,
  output vch_pkg::slot_entry_t rdata_o
);

  vch_pkg::slot_entry_t mem [vch_pkg::TABLE_DEPTH];
  vch_pkg::slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (port_i.we) begin
      mem[port_i.waddr] <= port_i.wdata;
    end
    rdata_q <= mem[port_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/vch_walk.sv =====
// command sequencer: clearing sweep, hash start, linear probe walk, result register
// drives vch_hash and vch_slot_ram through package structs; uses vch_pkg
module vch_walk (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [vch_pkg::LOG2_W-1:0]         table_log2_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [vch_pkg::CMD_W-1:0]          in_cmd_i,
  input  logic [vch_pkg::KEY_W-1:0]          in_key_i,
  input  logic [vch_pkg::VALUE_W-1:0]        in_value_i,
  output vch_pkg::hash_req_t                 hash_req_o,
  input  vch_pkg::hash_rsp_t                 hash_rsp_i,
  output vch_pkg::slot_port_t                ram_o,
  input  vch_pkg::slot_entry_t               ram_rdata_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output vch_pkg::result_t                   out_o
);

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_e;

  state_e                           state_q, state_d;
  logic [vch_pkg::SLOT_AW-1:0]      sweep_addr_q, sweep_addr_d;
  logic                             sweep_cmd_q, sweep_cmd_d;
  logic [vch_pkg::CMD_W-1:0]        cmd_q, cmd_d;
  logic [vch_pkg::KEY_W-1:0]        key_q, key_d;
  logic [vch_pkg::VALUE_W-1:0]      value_q, value_d;
  logic [vch_pkg::SLOT_AW-1:0]      slot_q, slot_d;
  logic [vch_pkg::SLOT_AW-1:0]      cnt_q, cnt_d;
  vch_pkg::result_t                 res_q, res_d;
  logic                             out_valid_q, out_valid_d;
  vch_pkg::result_t                 out_q, out_d;

  logic [vch_pkg::SLOT_AW-1:0]      mask, next_slot;
  logic                             is_insert;

  assign mask      = vch_pkg::slot_mask(table_log2_i);
  assign next_slot = (slot_q + vch_pkg::SLOT_AW'(1)) & mask;
  assign is_insert = (cmd_q == vch_pkg::CMD_INSERT);

  always_comb begin
    state_d      = state_q;
    sweep_addr_d = sweep_addr_q;
    sweep_cmd_d  = sweep_cmd_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    value_d      = value_q;
    slot_d       = slot_q;
    cnt_d        = cnt_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;

    hash_req_o.start = 1'b0;
    hash_req_o.key   = in_key_i;

    ram_o.we          = 1'b0;
    ram_o.waddr       = slot_q;
    ram_o.wdata.used  = 1'b1;
    ram_o.wdata.key   = key_q;
    ram_o.wdata.value = value_q;
    ram_o.raddr       = slot_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_SWEEP: begin
        ram_o.we     = 1'b1;
        ram_o.waddr  = sweep_addr_q;
        ram_o.wdata  = '0;
        sweep_addr_d = sweep_addr_q + vch_pkg::SLOT_AW'(1);
        if (sweep_addr_q == '1) begin
          sweep_cmd_d = 1'b0;
          if (sweep_cmd_q) begin
            res_d   = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_cmd_i;
          key_d   = in_key_i;
          value_d = in_value_i;
          unique case (in_cmd_i) inside
            vch_pkg::CMD_CLEAR: begin
              sweep_cmd_d  = 1'b1;
              sweep_addr_d = '0;
              state_d      = ST_SWEEP;
            end
            vch_pkg::CMD_INSERT, vch_pkg::CMD_LOOKUP: begin
              hash_req_o.start = 1'b1;
              state_d          = ST_HASH;
            end
            default: begin
              res_d   = '0;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_HASH: begin
        if (hash_rsp_i.done) begin
          slot_d  = hash_rsp_i.hash[vch_pkg::SLOT_AW-1:0] & mask;
          cnt_d   = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        res_d = '0;
        if (!ram_rdata_i.used) begin
          ram_o.we = is_insert;
          state_d  = ST_DONE;
        end else if (ram_rdata_i.key == key_q) begin
          res_d.found = 1'b1;
          ram_o.we    = is_insert;
          if (!is_insert) begin
            res_d.value = ram_rdata_i.value;
          end
          state_d = ST_DONE;
        end else if (cnt_q == mask) begin
          // every slot in use visited without a match
          res_d.status = is_insert;
          state_d      = ST_DONE;
        end else begin
          slot_d      = next_slot;
          cnt_d       = cnt_q + vch_pkg::SLOT_AW'(1);
          ram_o.raddr = next_slot;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      sweep_addr_q <= '0;
      sweep_cmd_q  <= 1'b0;
      cmd_q        <= '0;
      key_q        <= '0;
      value_q      <= '0;
      slot_q       <= '0;
      cnt_q        <= '0;
      res_q        <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_cmd_q  <= sweep_cmd_d;
      cmd_q        <= cmd_d;
      key_q        <= key_d;
      value_q      <= value_d;
      slot_q       <= slot_d;
      cnt_q        <= cnt_d;
      res_q        <= res_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== sv/voxel_coordinate_hash_table_unit.sv =====
// top level of the voxel coordinate hash table: stream ports, size register, key build
// instantiates vch_hash, vch_slot_ram and vch_walk; uses vch_pkg
//
// Maps 3-D voxel coordinates to a 20-bit entry index with an open-addressed
// table of 4096 slots and linear probing. Each input transaction carries one
// command (insert, lookup or clear) and returns exactly one result
// transaction. Items are handled one at a time: an insert or lookup first
// runs the key finalizer, which runs its two 64-bit multiplies through one
// shared 32x32 multiplier, and then probes slots one after another through
// the slot memory read port. A clear walks all 4096 slots, one per cycle.
// After reset the same clearing pass runs first and s_axis_tready stays low
// until it is over; the size register can be written at any time through
// the cfg channel but must only change while no command is in flight. A
// finished result waits in an output register, so the next command is taken
// while the result is stalled.
module voxel_coordinate_hash_table_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // size register write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [vch_pkg::LOG2_W-1:0]          cfg_data_i,     // table_log2
  // command stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // coord_x, coord_y, coord_z, entry_value, zero pad
  input  logic [vch_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic [vch_pkg::CMD_W-1:0]           s_axis_tuser,   // command
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [vch_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // result_value, zero pad
  output logic [1:0]                          m_axis_tuser    // found, status
);

  localparam int unsigned CB = vch_pkg::COORD_BITS;

  logic [vch_pkg::LOG2_W-1:0]   table_log2_q;

  logic [CB-1:0]                coord_x, coord_y, coord_z;
  logic [vch_pkg::VALUE_W-1:0]  entry_value;
  logic [vch_pkg::KEY_W-1:0]    raw_key, key;

  vch_pkg::hash_req_t           hash_req;
  vch_pkg::hash_rsp_t           hash_rsp;
  vch_pkg::slot_port_t          ram_port;
  vch_pkg::slot_entry_t         ram_rdata;
  vch_pkg::result_t             result;

  // size register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_log2_q <= vch_pkg::TABLE_LOG2_RST;
    end else if (cfg_valid_i) begin
      table_log2_q <= cfg_data_i;
    end
  end

  // unpack the command payload
  assign coord_x     = s_axis_tdata[CB-1:0];
  assign coord_y     = s_axis_tdata[2*CB-1:CB];
  assign coord_z     = s_axis_tdata[3*CB-1:2*CB];
  assign entry_value = s_axis_tdata[3*CB +: vch_pkg::VALUE_W];

  // x in the top third, z in the bottom; the all-zero key is reserved
  assign raw_key = {coord_x, coord_y, coord_z};
  assign key     = (raw_key == '0) ? vch_pkg::KEY_W'(1) : raw_key;

  vch_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hash_req),
    .rsp_o  (hash_rsp)
  );

  vch_slot_ram u_ram (
    .clk_i   (clk_i),
    .port_i  (ram_port),
    .rdata_o (ram_rdata)
  );

  vch_walk u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .table_log2_i (table_log2_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (s_axis_tuser),
    .in_key_i     (key),
    .in_value_i   (entry_value),
    .hash_req_o   (hash_req),
    .hash_rsp_i   (hash_rsp),
    .ram_o        (ram_port),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (result)
  );

  // pack the result transaction
  assign m_axis_tdata = vch_pkg::OUT_TDATA_W'(result.value);
  assign m_axis_tuser = {result.status, result.found};

endmodule

// ===== sv/vch_checker.sv =====
// port-level checks for voxel_coordinate_hash_table_unit, attached with bind
// sees only the top-level ports; uses vch_pkg for widths
module vch_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [vch_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [1:0]                       m_axis_tuser
);

  // clearing pass holds off commands right after reset
  a_sweep_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("command accepted during the reset clearing pass");

  // one command at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second command accepted while one is in flight");

  // a result that is not a hit (a miss, a clear, an unknown code) returns a zero value
  a_value_zero_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("nonzero result value without a hit");

  // a matched key never reports a full table
  a_found_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("found and table full reported together");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result transaction changed");

endmodule

bind voxel_coordinate_hash_table_unit vch_checker u_vch_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== bench/tb.sv =====
// testbench for voxel_coordinate_hash_table_unit: directed and random insert, lookup,
// clear and size traffic, checked against a shadow copy of the table kept here
// depends on vch_pkg and the rtl under test only
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned POOL_DEPTH    = 48;
  localparam int unsigned COORD_MAX     = (1 << vch_pkg::COORD_BITS) - 1;
  localparam int unsigned VALUE_MAX     = (1 << vch_pkg::VALUE_W) - 1;
  // tuser code the block does not know, must answer all zero
  localparam logic [vch_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef logic [vch_pkg::COORD_BITS-1:0] coord_t;
  typedef logic [vch_pkg::VALUE_W-1:0]    value_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } voxel_t;

  logic                               clk_i         = 1'b0;
  logic                               rst_ni        = 1'b0;
  logic                               cfg_valid_i   = 1'b0;
  logic                               cfg_ready_o;
  logic [vch_pkg::LOG2_W-1:0]         cfg_data_i    = '0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [vch_pkg::IN_TDATA_W-1:0]     s_axis_tdata  = '0;
  logic [vch_pkg::CMD_W-1:0]          s_axis_tuser  = '0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [vch_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
  logic [1:0]                         m_axis_tuser;

  voxel_coordinate_hash_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow of the table: contents, occupancy and the size register
  logic [vch_pkg::KEY_W-1:0]  shadow_key   [vch_pkg::TABLE_DEPTH];
  value_t                     shadow_value [vch_pkg::TABLE_DEPTH];
  bit                         shadow_used  [vch_pkg::TABLE_DEPTH];
  logic [vch_pkg::LOG2_W-1:0] size_log2 = vch_pkg::TABLE_LOG2_RST;

  vch_pkg::result_t answers_due[$];   // one per accepted command, oldest first
  voxel_t           known_voxels[$];  // coordinates already inserted, reused for hits

  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 76;
  int unsigned hold_len      = 0;     // requested output stall, in cycles
  logic        hold_active   = 1'b0;
  int unsigned failures      = 0;
  int unsigned results_seen  = 0;
  int unsigned cycles        = 0;

  function automatic logic [63:0] finalize_hash(logic [63:0] v);
    v = v ^ (v >> vch_pkg::MIX_SHIFT);
    v = v * vch_pkg::MIX_C1;
    v = v ^ (v >> vch_pkg::MIX_SHIFT);
    v = v * vch_pkg::MIX_C2;
    v = v ^ (v >> vch_pkg::MIX_SHIFT);
    return v;
  endfunction

  // slots in use: 2^log2, halved until it fits the memory
  function automatic int unsigned active_slots();
    int unsigned n;
    n = 1 << size_log2;
    while (n > vch_pkg::TABLE_DEPTH) n = n >> 1;
    return n;
  endfunction

  // applies one command to the shadow table and returns its answer
  function automatic vch_pkg::result_t hash_table_answer(logic [vch_pkg::CMD_W-1:0] code,
                                                         voxel_t c, value_t val);
    vch_pkg::result_t            r;
    logic [vch_pkg::KEY_W-1:0]   key;
    logic [63:0]                 h;
    logic [vch_pkg::SLOT_AW-1:0] mask, idx;
    int unsigned                 slots, n;
    bit                          settled;
    r = '0;
    if (code == vch_pkg::CMD_CLEAR) begin
      foreach (shadow_used[i]) shadow_used[i] = 1'b0;
    end else if (code == vch_pkg::CMD_INSERT || code == vch_pkg::CMD_LOOKUP) begin
      key = {c.x, c.y, c.z};
      if (key == '0) key = vch_pkg::KEY_W'(1);  // origin aliases to key one
      h = finalize_hash({1'b0, key});
      slots = active_slots();
      mask = vch_pkg::SLOT_AW'(slots - 1);
      idx = h[vch_pkg::SLOT_AW-1:0] & mask;
      settled = 1'b0;
      for (n = 0; n < slots && !settled; n++) begin
        if (!shadow_used[idx]) begin
          if (code == vch_pkg::CMD_INSERT) begin
            shadow_used[idx]  = 1'b1;
            shadow_key[idx]   = key;
            shadow_value[idx] = val;
          end
          settled = 1'b1;
        end else if (shadow_key[idx] == key) begin
          r.found = 1'b1;
          if (code == vch_pkg::CMD_INSERT) shadow_value[idx] = val;
          else r.value = shadow_value[idx];
          settled = 1'b1;
        end else begin
          idx = (idx + vch_pkg::SLOT_AW'(1)) & mask;
        end
      end
      // walked the whole table without a free slot or a match
      if (!settled && code == vch_pkg::CMD_INSERT) r.status = 1'b1;
    end
    return r;
  endfunction

  function automatic void log_failure(string what);
    failures++;
    if (failures <= 10) $display("%s", what);
  endfunction

  // result side: random ready, long holds on request, compare against oldest answer
  always @(negedge clk_i) begin
    if (hold_len != 0) begin
      hold_active = 1'b1;
      repeat (hold_len) @(negedge clk_i);
      hold_active = 1'b0;
      hold_len = 0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || hold_active) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    vch_pkg::result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.found  = m_axis_tuser[0];
      got.status = m_axis_tuser[1];
      got.value  = m_axis_tdata[vch_pkg::VALUE_W-1:0];
      results_seen++;
      if (answers_due.size() == 0) begin
        log_failure($sformatf("result %0d with nothing pending: found=%0b value=%h status=%0b",
                              results_seen, got.found, got.value, got.status));
      end else begin
        want = answers_due.pop_front();
        if (got.found !== want.found || got.value !== want.value ||
            got.status !== want.status) begin
          log_failure($sformatf({"result %0d mismatch: found exp %0b got %0b, ",
                                 "value exp %h got %h, status exp %0b got %0b"},
                                results_seen, want.found, got.found, want.value,
                                got.value, want.status, got.status));
        end
      end
    end
  end

  // one command transaction; the answer is predicted at the accepting edge
  task automatic send_item(input logic [vch_pkg::CMD_W-1:0] code, input voxel_t c,
                           input value_t val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= code;
    s_axis_tdata  <= {{(vch_pkg::IN_TDATA_W - vch_pkg::KEY_W - vch_pkg::VALUE_W){1'b0}},
                      val, c.z, c.y, c.x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    answers_due.push_back(hash_table_answer(code, c, val));
  endtask

  // drain every pending answer, then let the walk logic go quiet
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_table_log2(input logic [vch_pkg::LOG2_W-1:0] v);
    settle_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    size_log2 = v;
  endtask

  // mostly full-range coordinates, sometimes grid corners
  function automatic voxel_t fresh_voxel();
    voxel_t c;
    if ($urandom_range(0, 9) == 0) begin
      c.x = $urandom_range(0, 1) ? coord_t'(COORD_MAX) : '0;
      c.y = $urandom_range(0, 1) ? coord_t'(COORD_MAX) : '0;
      c.z = $urandom_range(0, 1) ? coord_t'(COORD_MAX) : '0;
    end else begin
      c.x = coord_t'($urandom_range(0, COORD_MAX));
      c.y = coord_t'($urandom_range(0, COORD_MAX));
      c.z = coord_t'($urandom_range(0, COORD_MAX));
    end
    return c;
  endfunction

  // inserts of new keys, overwrites and lookups of known keys, misses, rare noise
  task automatic random_item();
    voxel_t      c;
    value_t      v;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    v = value_t'($urandom_range(0, VALUE_MAX));
    if (pick < 35 || known_voxels.size() == 0) begin
      c = fresh_voxel();
      if (known_voxels.size() < POOL_DEPTH) known_voxels.push_back(c);
      else known_voxels[$urandom_range(0, POOL_DEPTH - 1)] = c;
      send_item(vch_pkg::CMD_INSERT, c, v);
    end else if (pick < 55) begin
      send_item(vch_pkg::CMD_INSERT, known_voxels[$urandom_range(0, known_voxels.size() - 1)], v);
    end else if (pick < 85) begin
      send_item(vch_pkg::CMD_LOOKUP, known_voxels[$urandom_range(0, known_voxels.size() - 1)], v);
    end else if (pick < 95) begin
      send_item(vch_pkg::CMD_LOOKUP, fresh_voxel(), v);
    end else if (pick < 99) begin
      send_item(CMD_UNUSED, fresh_voxel(), v);
    end else begin
      send_item(vch_pkg::CMD_CLEAR, fresh_voxel(), v);
    end
  endtask

  task automatic random_phase(input logic [vch_pkg::LOG2_W-1:0] log2, input int unsigned count,
                              input int unsigned send_pct, input int unsigned recv_pct);
    write_table_log2(log2);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) random_item();
  endtask

  // default size: origin aliasing, corner coordinates, overwrite, unknown code, clear
  task automatic test_key_corners();
    voxel_t corner_max, origin, key_one, x_only, y_only;
    corner_max = '{x: coord_t'(COORD_MAX), y: coord_t'(COORD_MAX), z: coord_t'(COORD_MAX)};
    origin     = '{x: '0, y: '0, z: '0};
    key_one    = '{x: '0, y: '0, z: coord_t'(1)};
    x_only     = '{x: coord_t'(COORD_MAX), y: '0, z: '0};
    y_only     = '{x: '0, y: coord_t'(COORD_MAX), z: '0};
    send_item(vch_pkg::CMD_INSERT, origin, value_t'(VALUE_MAX));
    send_item(vch_pkg::CMD_LOOKUP, key_one, '0);
    send_item(vch_pkg::CMD_INSERT, corner_max, '0);
    send_item(vch_pkg::CMD_LOOKUP, corner_max, value_t'(VALUE_MAX));
    send_item(vch_pkg::CMD_INSERT, x_only, 20'h5a5a5);
    send_item(vch_pkg::CMD_INSERT, key_one, 20'h00001);
    send_item(vch_pkg::CMD_LOOKUP, origin, '0);
    send_item(vch_pkg::CMD_LOOKUP, y_only, '0);
    send_item(CMD_UNUSED, corner_max, value_t'(VALUE_MAX));
    send_item(vch_pkg::CMD_CLEAR, corner_max, '0);
    send_item(vch_pkg::CMD_LOOKUP, corner_max, '0);
  endtask

  // one-slot table: second key is dropped, lookup of it misses, first key still updates
  task automatic test_single_slot_full();
    voxel_t a, b;
    a = '{x: coord_t'(5), y: coord_t'(6), z: coord_t'(7)};
    b = '{x: coord_t'(9), y: coord_t'(10), z: coord_t'(11)};
    write_table_log2(4'd0);
    send_item(vch_pkg::CMD_INSERT, a, 20'd3);
    send_item(vch_pkg::CMD_INSERT, b, 20'd4);
    send_item(vch_pkg::CMD_LOOKUP, b, '0);
    send_item(vch_pkg::CMD_INSERT, a, 20'd9);
    send_item(vch_pkg::CMD_LOOKUP, a, '0);
  endtask

  // fill at eight slots, then shrink and regrow past the memory size with contents kept
  task automatic test_resize_with_contents();
    voxel_t filled[5];
    foreach (filled[i]) filled[i] = fresh_voxel();
    write_table_log2(4'd3);
    foreach (filled[i]) begin
      send_item(vch_pkg::CMD_INSERT, filled[i], value_t'($urandom_range(0, VALUE_MAX)));
    end
    write_table_log2(4'd1);
    send_item(vch_pkg::CMD_LOOKUP, filled[0], '0);
    send_item(vch_pkg::CMD_LOOKUP, filled[3], '0);
    write_table_log2(4'd13);
    send_item(vch_pkg::CMD_LOOKUP, filled[1], '0);
    send_item(vch_pkg::CMD_LOOKUP, filled[4], '0);
  endtask

  task automatic test_sparse_and_crowded();
    random_phase(4'd12, 250, 32, 76);
    random_phase(4'd3,  200, 32, 76);
    random_phase(4'd15, 150, 76, 32);
    random_phase(4'd5,  250, 76, 32);
    random_phase(4'd1,  100, 0, 0);
  endtask

  // result side held off while commands keep coming, so the input stalls
  task automatic test_output_backpressure();
    write_table_log2(4'd6);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len = 300;
    repeat (40) random_item();
    repeat (260) random_item();
  endtask

  initial begin
    foreach (shadow_used[i]) shadow_used[i] = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_key_corners();
    test_single_slot_full();
    test_resize_with_contents();
    test_sparse_and_crowded();
    test_output_backpressure();
    settle_idle();
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
